/* sv/gdn_pkg.sv */
package gdn_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned DNUM_W   = 22;
	localparam int unsigned WDAY_W   = 3;
	localparam int unsigned CENT_W   = 8;   // year / 100, up to 163
	localparam int unsigned BASE_W   = 23;  // whole-year day count before truncation
	localparam int unsigned MOFS_W   = 9;   // days before the month, up to 335
	localparam int unsigned ZSUM_W   = 11;  // Zeller sum before mod 7, up to about 1050

	localparam int unsigned MAX_YEAR = 9999;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
	localparam int unsigned RECIP_100   = 5243;
	localparam int unsigned RECIP_W     = 13;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} gdn_date_t;

	typedef struct packed {
		gdn_date_t         date;
		logic [CENT_W-1:0] cent;
	} gdn_cent_t;

	typedef struct packed {
		logic              ok;
		logic [BASE_W-1:0] base;
		logic [MOFS_W-1:0] mofs;
		logic [DAY_W-1:0]  day;
		logic [ZSUM_W-1:0] zsum;
	} gdn_eval_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		case (m)
			4'd1:    return 5'd31;
			4'd2:    return 5'd28;
			4'd3:    return 5'd31;
			4'd4:    return 5'd30;
			4'd5:    return 5'd31;
			4'd6:    return 5'd30;
			4'd7:    return 5'd31;
			4'd8:    return 5'd31;
			4'd9:    return 5'd30;
			4'd10:   return 5'd31;
			4'd11:   return 5'd30;
			4'd12:   return 5'd31;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [MOFS_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		case (m)
			4'd1:    return 9'd0;
			4'd2:    return 9'd31;
			4'd3:    return 9'd59;
			4'd4:    return 9'd90;
			4'd5:    return 9'd120;
			4'd6:    return 9'd151;
			4'd7:    return 9'd181;
			4'd8:    return 9'd212;
			4'd9:    return 9'd243;
			4'd10:   return 9'd273;
			4'd11:   return 9'd304;
			4'd12:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

	// (13 * (m' + 1)) / 5 with Jan/Feb moved to months 13 and 14
	function automatic logic [5:0] zeller_mterm(input logic [MONTH_W-1:0] m);
		case (m)
			4'd1:    return 6'd36;
			4'd2:    return 6'd39;
			4'd3:    return 6'd10;
			4'd4:    return 6'd13;
			4'd5:    return 6'd15;
			4'd6:    return 6'd18;
			4'd7:    return 6'd20;
			4'd8:    return 6'd23;
			4'd9:    return 6'd26;
			4'd10:   return 6'd28;
			4'd11:   return 6'd31;
			4'd12:   return 6'd33;
			default: return 6'd0;
		endcase
	endfunction

endpackage

/* sv/gregorian_date_to_day_number.sv */
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   year[13:0], month[3:0], day[4:0]
// output    out        out_valid / out_stall date_valid, day_number[21:0], weekday[2:0]
//
// One date per cycle sustained while out_stall is low; a transfer on the input
// passes through four registers to the output: input reg, divide-by-100
// multiply, evaluation adder stage, output reg.
// arst_n clears the stage valid bits only; payload registers are not reset.
// out_stall backs up stage by stage; in_stall rises only once every stage
// holds an item, so empty stages keep taking transfers during an output stall.
module gregorian_date_to_day_number import gdn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                date_valid,
	output logic [DNUM_W-1:0]   day_number,
	output logic [WDAY_W-1:0]   weekday
);

	// per-stage valid and load enables
	logic v_s1, v_s2, v_s3, out_v_q;
	logic ld_s1, ld_s2, ld_s3, ld_out;

	gdn_date_t date_s1;
	gdn_cent_t cent_c, cent_s2;
	gdn_eval_t eval_c, eval_s3;

	logic              ok_c;
	logic [DNUM_W-1:0] dnum_c;
	logic [WDAY_W-1:0] wday_c;

	logic              date_valid_q;
	logic [DNUM_W-1:0] day_number_q;
	logic [WDAY_W-1:0] weekday_q;

	// a stage loads when empty or when its contents move on
	assign ld_out = !out_v_q || !out_stall;
	assign ld_s3  = !v_s3 || ld_out;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;

	assign in_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1    <= in_valid;
			if (ld_s2)  v_s2    <= v_s1;
			if (ld_s3)  v_s3    <= v_s2;
			if (ld_out) out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			date_s1.year  <= year;
			date_s1.month <= month;
			date_s1.day   <= day;
		end
		if (ld_s2) begin
			cent_s2 <= cent_c;
		end
		if (ld_s3) begin
			eval_s3 <= eval_c;
		end
		if (ld_out) begin
			date_valid_q <= ok_c;
			day_number_q <= dnum_c;
			weekday_q    <= wday_c;
		end
	end

	gdn_div100 u_div100 (
		.date (date_s1),
		.cent (cent_c)
	);

	gdn_eval u_eval (
		.cin (cent_s2),
		.res (eval_c)
	);

	gdn_final u_final (
		.ev   (eval_s3),
		.ok   (ok_c),
		.dnum (dnum_c),
		.wday (wday_c)
	);

	assign out_valid  = out_v_q;
	assign date_valid = date_valid_q;
	assign day_number = day_number_q;
	assign weekday    = weekday_q;

	// invalid dates carry all-zero results
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !date_valid |-> (day_number == '0) && (weekday == '0))
		else $error("invalid date with nonzero result");

	// weekday stays within Saturday..Friday
	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid |-> weekday <= WDAY_W'(6))
		else $error("weekday out of range");

	// a valid date never counts as day zero
	a_dnum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid |-> day_number != '0)
		else $error("valid date with day number zero");

	// input only backs up when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && out_v_q && out_stall)
		else $error("input stalled with a free stage");

endmodule

/* sv/gdn_div100.sv */
module gdn_div100 import gdn_pkg::*; (
	input  gdn_date_t date,
	output gdn_cent_t cent
);

	logic [YEAR_W+RECIP_W-1:0] prod;

	// reciprocal multiply, exact over the whole 14-bit range
	assign prod = YEAR_W'(date.year) * RECIP_W'(RECIP_100);

	assign cent.date = date;
	assign cent.cent = prod[RECIP_SHIFT +: CENT_W];

endmodule

/* sv/gdn_eval.sv */
module gdn_eval import gdn_pkg::*; (
	input  gdn_cent_t cin,
	output gdn_eval_t res
);

	logic [YEAR_W-1:0]  y;
	logic [MONTH_W-1:0] m;
	logic [DAY_W-1:0]   d;
	logic [CENT_W-1:0]  q;
	logic [CENT_W-1:0]  qp;
	logic [6:0]         r;
	logic [6:0]         k;
	logic [CENT_W-1:0]  j;
	logic [YEAR_W-1:0]  py;
	logic               leap;
	logic               early;
	logic [DAY_W-1:0]   mlen;

	assign y = cin.date.year;
	assign m = cin.date.month;
	assign d = cin.date.day;
	assign q = cin.cent;

	// y mod 100
	assign r = 7'(y - YEAR_W'(q) * YEAR_W'(100));

	// divisible by 400 <=> mod 100 is zero and century divisible by 4
	assign leap = (y[1:0] == 2'd0) && ((r != 7'd0) || (q[1:0] == 2'd0));

	assign mlen = month_len(m) + DAY_W'((m == MONTH_FEB) && leap);

	assign res.ok = (y != '0) && ({1'b0, y} <= 15'(MAX_YEAR))
		&& (m >= MONTH_JAN) && (m <= MONTH_DEC)
		&& (d != '0) && (d <= mlen);

	// previous year and its century
	assign py = y - YEAR_W'(1);
	assign qp = (r == 7'd0) ? q - CENT_W'(1) : q;

	assign res.base = BASE_W'(py) * BASE_W'(365) + BASE_W'(py >> 2)
		- BASE_W'(qp) + BASE_W'(qp >> 2);

	assign res.mofs = days_before(m) + MOFS_W'((m > MONTH_FEB) && leap);
	assign res.day  = d;

	// Zeller: Jan and Feb belong to the previous year
	assign early = (m < MONTH_MAR);
	assign k = early ? ((r == 7'd0) ? 7'd99 : r - 7'd1) : r;
	assign j = early ? qp : q;

	assign res.zsum = ZSUM_W'(d) + ZSUM_W'(zeller_mterm(m)) + ZSUM_W'(k)
		+ ZSUM_W'(k >> 2) + ZSUM_W'(j >> 2) + ZSUM_W'(j) * ZSUM_W'(5);

endmodule

/* sv/gdn_final.sv */
module gdn_final import gdn_pkg::*; (
	input  gdn_eval_t          ev,
	output logic               ok,
	output logic [DNUM_W-1:0]  dnum,
	output logic [WDAY_W-1:0]  wday
);

	logic [BASE_W-1:0] total;
	logic [4:0]        fold1;
	logic [3:0]        fold2;
	logic [2:0]        m7;

	assign total = ev.base + BASE_W'(ev.mofs) + BASE_W'(ev.day);

	// mod 7 by summing octal digits (8 == 1 mod 7)
	assign fold1 = 5'(ev.zsum[2:0]) + 5'(ev.zsum[5:3]) + 5'(ev.zsum[8:6])
		+ 5'(ev.zsum[10:9]);
	assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
	assign m7    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

	assign ok   = ev.ok;
	assign dnum = ev.ok ? total[DNUM_W-1:0] : '0;
	assign wday = ev.ok ? m7 : '0;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import gdn_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;   // pipeline is four deep, a few spare

	localparam int unsigned MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned DAYS_AHEAD[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
		304, 334};

	typedef struct packed {
		logic              ok;
		logic [DNUM_W-1:0] num;
		logic [WDAY_W-1:0] wd;
	} day_result_t;

	// Gregorian rule: every fourth year, except centuries not divisible by 400
	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		return MONTH_DAYS[m-1] + ((m == MONTH_FEB && leap_year(y)) ? 1 : 0);
	endfunction

	// Holds the day number / weekday for every date transfer still in flight
	class date_ledger;
		day_result_t due_days[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function day_result_t convert_date(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
			day_result_t r;
			int unsigned py, num, zy, zm, k, j;
			r = '0;
			if (y == 0 || y > MAX_YEAR || m == 0 || m > MONTH_DEC || d == 0)
				return r;
			if (d > days_in_month(y, m))
				return r;
			py = y - 1;
			num = py * 365 + py / 4 - py / 100 + py / 400;
			num += DAYS_AHEAD[m-1] + ((m > MONTH_FEB && leap_year(y)) ? 1 : 0) + d;
			// Zeller: Jan and Feb count as months 13 and 14 of the year before
			zy = y;
			zm = m;
			if (zm < MONTH_MAR) begin
				zm += 12;
				zy -= 1;
			end
			k = zy % 100;
			j = zy / 100;
			r.ok  = 1'b1;
			r.num = num[DNUM_W-1:0];
			r.wd  = WDAY_W'((d + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
			return r;
		endfunction

		function void note_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d);
			due_days.push_back(convert_date(y, m, d));
		endfunction

		function void check_result(input logic v, input logic [DNUM_W-1:0] n,
			input logic [WDAY_W-1:0] w);
			day_result_t e;
			if (due_days.size() == 0) begin
				$display("%0t: result with nothing pending: date_valid %0d day_number %0d weekday %0d",
					$time, v, n, w);
				errors++;
				return;
			end
			e = due_days.pop_front();
			if (v !== e.ok) begin
				$display("%0t: date_valid expected %0d got %0d", $time, e.ok, v);
				errors++;
			end
			if (n !== e.num) begin
				$display("%0t: day_number expected %0d got %0d", $time, e.num, n);
				errors++;
			end
			if (w !== e.wd) begin
				$display("%0t: weekday expected %0d got %0d", $time, e.wd, w);
				errors++;
			end
		endfunction

		function int pending();
			return due_days.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [YEAR_W-1:0]  year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [DAY_W-1:0]   day = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               date_valid;
	logic [DNUM_W-1:0]  day_number;
	logic [WDAY_W-1:0]  weekday;

	int gap_pct = 0;     // chance per cycle that the sender idles
	int stall_pct = 0;   // chance per cycle that the receiver stalls
	int cycles = 0;

	date_ledger ledger = new();

	gregorian_date_to_day_number i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.year       (year),
		.month      (month),
		.day        (day),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.date_valid (date_valid),
		.day_number (day_number),
		.weekday    (weekday)
	);

	always #10 clk = ~clk;

	// Watchdog: anything hung (lost result, stuck stall) ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("gregorian_date_to_day_number: mismatch");
			$finish;
		end
	end

	// Receiver backpressure, changed on the falling edge only
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Both monitors sample on the rising edge, before any register updates
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			ledger.note_date(year, month, day);
		if (arst_n && out_valid && !out_stall)
			ledger.check_result(date_valid, day_number, weekday);
	end

	// One date transfer: random idle cycles first, then hold until taken.
	// No falling edge gets more than one drive of in_valid.
	task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0] d);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			year     <= YEAR_W'($urandom);
			month    <= MONTH_W'($urandom);
			day      <= DAY_W'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		year     <= y;
		month    <= m;
		day      <= d;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold off until the pipeline has handed back everything
	task automatic drain_pipe();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly legal dates with random content, the rest raw bit patterns
	task automatic run_phase(input int count, input int gp, input int sp);
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		int unsigned lim;
		gap_pct   = gp;
		stall_pct = sp;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 70) begin
				case ($urandom_range(3))
					0: y = YEAR_W'($urandom_range(1, MAX_YEAR));
					1: y = YEAR_W'(100 * $urandom_range(1, MAX_YEAR / 100));
					2: y = YEAR_W'(4 * $urandom_range(1, MAX_YEAR / 4));
					default: y = ($urandom_range(1) != 0) ? YEAR_W'($urandom_range(1, 40))
						: YEAR_W'($urandom_range(MAX_YEAR - 30, MAX_YEAR + 30));
				endcase
				m = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
				lim = days_in_month(y, m);
				case ($urandom_range(7))
					0: d = DAY_W'(lim);
					1: d = DAY_W'((lim < 31) ? lim + 1 : lim);   // one past month end, or the last day of a 31-day month
					default: d = DAY_W'($urandom_range(1, lim));
				endcase
			end else begin
				y = YEAR_W'($urandom);
				m = MONTH_W'($urandom);
				d = DAY_W'($urandom);
			end
			send_date(y, m, d);
		end
		drain_pipe();
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, leap rules, month edges
		gap_pct   = 22;
		stall_pct = 48;
		send_date(14'd1, 4'd1, 5'd1);          // first day of the count
		send_date(14'd0, 4'd1, 5'd1);          // year zero
		send_date(14'd0, 4'd0, 5'd0);          // all fields zero
		send_date(14'd9999, 4'd12, 5'd31);     // last accepted day
		send_date(14'd10000, 4'd1, 5'd1);      // just past the largest year
		send_date(14'd16383, 4'd15, 5'd31);    // all ones
		send_date(14'd2020, 4'd0, 5'd10);      // month zero
		send_date(14'd2020, 4'd13, 5'd10);     // month past December
		send_date(14'd2020, 4'd15, 5'd10);
		send_date(14'd2020, 4'd6, 5'd0);       // day zero
		send_date(14'd2021, 4'd4, 5'd31);      // past end of a 30-day month
		send_date(14'd2021, 4'd1, 5'd31);
		send_date(14'd2000, 4'd2, 5'd29);      // leap by the 400 rule
		send_date(14'd1900, 4'd2, 5'd29);      // century, not leap
		send_date(14'd2004, 4'd2, 5'd29);      // ordinary leap year
		send_date(14'd2001, 4'd2, 5'd29);      // common year
		send_date(14'd2000, 4'd2, 5'd30);
		send_date(14'd2000, 4'd3, 5'd1);       // day after leap day
		send_date(14'd1900, 4'd3, 5'd1);
		send_date(14'd400, 4'd12, 5'd31);
		send_date(14'd1582, 4'd10, 5'd15);
		send_date(14'd2024, 4'd12, 5'd31);
		drain_pipe();

		// Random: receiver-heavy stalling, then sender-heavy idling, then flat out
		run_phase(270, 22, 48);
		run_phase(270, 48, 22);
		run_phase(270, 0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, ledger.pending());
			ledger.errors++;
		end
		if (ledger.errors == 0)
			$display("gregorian_date_to_day_number: match");
		else
			$display("gregorian_date_to_day_number: mismatch");
		$finish;
	end

endmodule
